@@ rtl/core/image_format_sniffer_macros.svh @@
// assertion macros shared by the sniffer rtl
// expects i_clk and i_rst_n in the scope of every use
`ifndef IMAGE_FORMAT_SNIFFER_MACROS_SVH
`define IMAGE_FORMAT_SNIFFER_MACROS_SVH
`ifndef ASSERT_OFF
`define ISF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ISF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ISF_ASSERT_IMPL(lbl, ante, cons, msg)
`define ISF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/isf_pkg.sv @@
// shared constants, types and signature helpers of the image format sniffer
// no dependencies
`default_nettype none

package isf_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int HEADER_BYTES = 52;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int HDR_AW       = $clog2(HEADER_BYTES);
    localparam int CODE_W       = 5;
    localparam int BCNT_W       = 13;

    // format codes
    localparam logic [CODE_W-1:0] FMT_UNKNOWN  = 5'd0;
    localparam logic [CODE_W-1:0] FMT_BMP      = 5'd1;
    localparam logic [CODE_W-1:0] FMT_GIF      = 5'd2;
    localparam logic [CODE_W-1:0] FMT_PNG      = 5'd3;
    localparam logic [CODE_W-1:0] FMT_TGA      = 5'd4;
    localparam logic [CODE_W-1:0] FMT_PCX      = 5'd5;
    localparam logic [CODE_W-1:0] FMT_JPEG     = 5'd6;
    localparam logic [CODE_W-1:0] FMT_META     = 5'd7;
    localparam logic [CODE_W-1:0] FMT_TIFF     = 5'd8;
    localparam logic [CODE_W-1:0] FMT_ICO      = 5'd9;
    localparam logic [CODE_W-1:0] FMT_WSHOTS   = 5'd10;
    localparam logic [CODE_W-1:0] FMT_PSD      = 5'd11;
    localparam logic [CODE_W-1:0] FMT_RAS      = 5'd12;
    localparam logic [CODE_W-1:0] FMT_JPEG2000 = 5'd13;
    localparam logic [CODE_W-1:0] FMT_SFW      = 5'd14;
    localparam logic [CODE_W-1:0] FMT_SVM      = 5'd15;
    localparam logic [CODE_W-1:0] FMT_SWF      = 5'd16;

    // running match flags, one per signature term
    localparam int OK_BMP    = 0;
    localparam int OK_GIF    = 1;
    localparam int OK_PNG    = 2;
    localparam int OK_TGA_A1 = 3;
    localparam int OK_TGA_A0 = 4;
    localparam int OK_TGA_B1 = 5;
    localparam int OK_TGA_B0 = 6;
    localparam int OK_TGA_T  = 7;
    localparam int OK_PCX    = 8;
    localparam int OK_JPEG   = 9;
    localparam int OK_EMF    = 10;
    localparam int OK_WMF_A  = 11;
    localparam int OK_WMF_B  = 12;
    localparam int OK_TIFF_I = 13;
    localparam int OK_TIFF_M = 14;
    localparam int OK_ICO_Z  = 15;
    localparam int OK_WS1    = 16;
    localparam int OK_WS2    = 17;
    localparam int OK_PSD    = 18;
    localparam int OK_RAS    = 19;
    localparam int OK_J2K    = 20;
    localparam int OK_JP2    = 21;
    localparam int OK_MJ2    = 22;
    localparam int OK_SFW    = 23;
    localparam int OK_SVM    = 24;
    localparam int OK_SWF_F  = 25;
    localparam int OK_SWF_C  = 26;
    localparam int NUM_OK    = 27;

    // byte strings, first byte in the highest lane of the used width
    localparam logic [383:0] SIG_PNG = 384'(128'h89504E47_0D0A1A0A_0000000D_49484452);
    localparam logic [383:0] SIG_WB2 = 384'(128'h00000200_0210C900_0200C806_4C000200);
    localparam logic [383:0] SIG_BOX = 384'(120'h0000000C_6A502020_0D0A870A_000000);
    localparam logic [383:0] SIG_SFW = 384'({
        128'h53465739_34410400_10000100_64000000,
        128'hCC000000_3B000000_DA070000_07010000,
        96'h44000000_D0070000_4B010000});
    localparam logic [383:0] SIG_SVM = {
        128'h56434C4D_54460100_31000000_01000000,
        128'h01001B00_00000000_00000000_00000000,
        128'h01000000_01000000_01000000_01000000};

    typedef struct packed {
        logic       take;
        logic       rd_en;
        logic [1:0] rd_lane;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // byte at pos matches a string placed at start, or lies outside it
    function automatic logic str_ok(input logic [HDR_AW-1:0] pos, input logic [7:0] b,
                                    input int start, input int len,
                                    input logic [383:0] str);
        int   k;
        logic ok;
        k  = int'(pos) - start;
        ok = 1'b1;
        if (k >= 0 && k < len) begin
            ok = (b == str[8*(len-1-k) +: 8]);
        end
        return ok;
    endfunction

    function automatic logic eq_at(input logic [HDR_AW-1:0] pos, input logic [7:0] b,
                                   input int idx, input logic [7:0] val);
        return (int'(pos) != idx) || (b == val);
    endfunction

    // per-term verdict on one header byte
    function automatic logic [NUM_OK-1:0] byte_ok(input logic [HDR_AW-1:0] pos,
                                                  input logic [7:0] b);
        logic [NUM_OK-1:0] ok;
        ok = '1;
        ok[OK_BMP] = str_ok(pos, b, 0, 2, 384'(16'h424D)) && eq_at(pos, b, 6, 8'h00)
                  && eq_at(pos, b, 7, 8'h00) && eq_at(pos, b, 26, 8'h01)
                  && eq_at(pos, b, 27, 8'h00) && eq_at(pos, b, 29, 8'h00)
                  && ((int'(pos) != 28) || (b inside {8'h00, 8'h01, 8'h04, 8'h08,
                                                      8'h10, 8'h18, 8'h20}))
                  && ((int'(pos) != 30) || (b <= 8'd5))
                  && str_ok(pos, b, 31, 3, 384'(24'h000000));
        ok[OK_GIF]    = str_ok(pos, b, 0, 4, 384'(32'h47494638));
        ok[OK_PNG]    = str_ok(pos, b, 0, 16, SIG_PNG);
        ok[OK_TGA_A1] = eq_at(pos, b, 1, 8'h01);
        ok[OK_TGA_A0] = eq_at(pos, b, 1, 8'h00);
        ok[OK_TGA_B1] = (int'(pos) != 2) || (b inside {8'd1, 8'd9});
        ok[OK_TGA_B0] = (int'(pos) != 2) || (b inside {8'd2, 8'd3, 8'd10, 8'd11});
        ok[OK_TGA_T]  = (int'(pos) != 16) || (b inside {8'd8, 8'd16, 8'd24, 8'd32});
        ok[OK_PCX]    = eq_at(pos, b, 0, 8'h0A) && ((int'(pos) != 1) || (b <= 8'd5))
                     && ((int'(pos) != 3) || (b inside {8'd1, 8'd2, 8'd4, 8'd8}));
        ok[OK_JPEG]   = str_ok(pos, b, 0, 3, 384'(24'hFFD8FF));
        ok[OK_EMF]    = str_ok(pos, b, 0, 4, 384'(32'h01000000))
                     && str_ok(pos, b, 40, 4, 384'(32'h20454D46));
        ok[OK_WMF_A]  = str_ok(pos, b, 0, 6, 384'(48'hD7CDC69A0000));
        ok[OK_WMF_B]  = str_ok(pos, b, 0, 6, 384'(48'h010009000003));
        ok[OK_TIFF_I] = str_ok(pos, b, 0, 4, 384'(32'h49492A00));
        ok[OK_TIFF_M] = str_ok(pos, b, 0, 4, 384'(32'h4D4D002A));
        ok[OK_ICO_Z]  = str_ok(pos, b, 0, 2, 384'(16'h0000));
        ok[OK_WS1]    = str_ok(pos, b, 0, 8, 384'(64'h57574242_31313131));
        ok[OK_WS2]    = str_ok(pos, b, 0, 16, SIG_WB2);
        ok[OK_PSD]    = str_ok(pos, b, 0, 4, 384'(32'h38425053))
                     && str_ok(pos, b, 6, 6, 384'(48'h000018000018));
        ok[OK_RAS]    = str_ok(pos, b, 0, 6, 384'(48'h59A66A950000))
                     && eq_at(pos, b, 15, 8'h18);
        ok[OK_J2K]    = str_ok(pos, b, 0, 4, 384'(32'hFF4FFF51));
        ok[OK_JP2]    = str_ok(pos, b, 0, 15, SIG_BOX)
                     && str_ok(pos, b, 16, 8, 384'(64'h66747970_6A703220))
                     && str_ok(pos, b, 24, 4, 384'(32'h00000000));
        ok[OK_MJ2]    = str_ok(pos, b, 0, 15, SIG_BOX) && eq_at(pos, b, 15, 8'h18)
                     && str_ok(pos, b, 16, 8, 384'(64'h66747970_6D6A7032))
                     && str_ok(pos, b, 24, 4, 384'(32'h00000000))
                     && str_ok(pos, b, 28, 4, 384'(32'h6D6A7032));
        ok[OK_SFW]    = str_ok(pos, b, 0, 44, SIG_SFW);
        ok[OK_SVM]    = str_ok(pos, b, 0, 48, SIG_SVM);
        ok[OK_SWF_F]  = str_ok(pos, b, 0, 3, 384'(24'h465753)) && eq_at(pos, b, 9, 8'h00);
        ok[OK_SWF_C]  = str_ok(pos, b, 0, 3, 384'(24'h435753))
                     && str_ok(pos, b, 8, 2, 384'(16'h789C));
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/isf_ifs.sv @@
// valid/ready channel interfaces of the image format sniffer
// depends on isf_pkg
`default_nettype none

interface isf_in_if;
    import isf_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface isf_out_if;
    import isf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] format_code;
    logic [BCNT_W-1:0] byte_count;

    modport source (output valid, output format_code, output byte_count, input ready);
    modport sink   (input valid, input format_code, input byte_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/isf_ctrl.sv @@
// sniffer controller: byte intake, icon word read sequence, result hand-off
// depends on isf_pkg and image_format_sniffer_macros.svh
`default_nettype none
`include "image_format_sniffer_macros.svh"

module isf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  isf_pkg::t_sts i_sts,
    output isf_pkg::t_cmd o_cmd
);
    import isf_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_READ,
        S_MERGE,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_in_ready, n_in_ready;

    assign o_in_ready    = r_in_ready;
    assign o_cmd.take    = i_in_valid && r_in_ready;
    assign o_cmd.rd_en   = (r_state == S_READ);
    assign o_cmd.rd_lane = r_k;
    assign o_cmd.emit    = (r_state == S_EMIT) && i_sts.out_free;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_in_ready = r_in_ready;
        case (r_state)
            S_RUN: begin
                if (o_cmd.take && i_in_last) begin
                    n_state    = S_READ;
                    n_k        = 2'd0;
                    n_in_ready = 1'b0;
                end
            end
            S_READ: begin
                // four byte reads of the icon width word
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state    = S_RUN;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_RUN;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_k        <= 2'd0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_in_ready <= n_in_ready;
        end
    end

    `ISF_ASSERT_NEXT(a_last_starts_read, o_cmd.take && i_in_last, r_state == S_READ && r_k == 2'd0, "last word did not start the read sequence")
    `ISF_ASSERT_NEXT(a_read_ends, r_state == S_READ && r_k == 2'd3, r_state == S_MERGE, "read sequence overran")
    `ISF_ASSERT_IMPL(a_ready_in_run, r_in_ready, r_state == S_RUN, "ready outside intake state")
    `ISF_ASSERT_IMPL(a_emit_needs_room, o_cmd.emit, i_sts.out_free, "result issued into a full output")

endmodule

`default_nettype wire

@@ rtl/core/isf_dpath.sv @@
// sniffer datapath: header store, running signature flags, icon capture,
// classification and output register; depends on isf_pkg and the macro header
`default_nettype none
`include "image_format_sniffer_macros.svh"

module isf_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  isf_pkg::t_cmd             i_cmd,
    output isf_pkg::t_sts             o_sts,
    input  logic [7:0]                i_data_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [isf_pkg::CODE_W-1:0] o_format_code,
    output logic [isf_pkg::BCNT_W-1:0] o_byte_count
);
    import isf_pkg::*;

    // header bytes, written once per file position
    logic [7:0]         r_hdr [HEADER_BYTES];

    logic [CNT_W-1:0]   r_count;
    logic [31:0]        r_off;
    logic [31:0]        r_iw;
    logic               r_iwv;
    logic [7:0]         r_w6;
    logic [NUM_OK-1:0]  r_ok;
    logic [7:0]         r_rd_data;
    logic [1:0]         r_rd_lane;
    logic               r_rd_vld;
    logic [31:0]        r_mword;
    logic               r_out_valid;
    logic [CODE_W-1:0]  r_code;
    logic [BCNT_W-1:0]  r_bc;

    logic               in_buf;
    logic               in_hdr;
    logic [HDR_AW-1:0]  pos;
    logic [NUM_OK-1:0]  n_ok;
    logic [32:0]        lo;
    logic [32:0]        diff;
    logic               cap;
    logic [1:0]         off_lane;
    logic [HDR_AW-1:0]  rd_addr;
    logic               near_off;
    logic [31:0]        ico_w;
    logic [31:0]        ico_word;
    logic               ico;
    logic [CODE_W-1:0]  n_code;

    assign in_buf   = r_count < CNT_W'(BUFFER_BYTES);
    assign in_hdr   = r_count < CNT_W'(HEADER_BYTES);
    assign pos      = r_count[HDR_AW-1:0];
    assign n_ok     = r_ok & byte_ok(pos, i_data_byte);
    assign off_lane = 2'(r_count - CNT_W'(18));

    // width word position is known once the offset bytes are in
    assign lo   = {1'b0, r_off} + 33'd4;
    assign diff = 33'(r_count) - lo;
    assign cap  = (r_count >= CNT_W'(22)) && (33'(r_count) >= lo) && (diff < 33'd4);

    // the word lies inside the stored header when offset + 7 < 52
    assign near_off = r_off < 32'd45;
    assign rd_addr  = near_off ? (r_off[HDR_AW-1:0] + HDR_AW'(4) + HDR_AW'(i_cmd.rd_lane))
                               : '0;

    assign ico_w    = (r_w6 == 8'd0) ? 32'd256 : {24'd0, r_w6};
    assign ico_word = near_off ? r_mword : r_iw;
    assign ico      = (r_count >= CNT_W'(40)) && r_ok[OK_ICO_Z]
                   && (({1'b0, r_off} + 33'd40) < 33'(r_count))
                   && (near_off || r_iwv) && (ico_word == ico_w);

    always_comb begin
        if ((r_count >= CNT_W'(34)) && r_ok[OK_BMP]) begin
            n_code = FMT_BMP;
        end else if ((r_count >= CNT_W'(4)) && r_ok[OK_GIF]) begin
            n_code = FMT_GIF;
        end else if ((r_count >= CNT_W'(16)) && r_ok[OK_PNG]) begin
            n_code = FMT_PNG;
        end else if ((r_count >= CNT_W'(17)) && r_ok[OK_TGA_T]
                     && ((r_ok[OK_TGA_A1] && r_ok[OK_TGA_B1])
                         || (r_ok[OK_TGA_A0] && r_ok[OK_TGA_B0]))) begin
            n_code = FMT_TGA;
        end else if ((r_count >= CNT_W'(4)) && r_ok[OK_PCX]) begin
            n_code = FMT_PCX;
        end else if ((r_count >= CNT_W'(3)) && r_ok[OK_JPEG]) begin
            n_code = FMT_JPEG;
        end else if ((r_count >= CNT_W'(44)) && r_ok[OK_EMF]) begin
            n_code = FMT_META;
        end else if ((r_count >= CNT_W'(6)) && (r_ok[OK_WMF_A] || r_ok[OK_WMF_B])) begin
            n_code = FMT_META;
        end else if ((r_count >= CNT_W'(4)) && (r_ok[OK_TIFF_I] || r_ok[OK_TIFF_M])) begin
            n_code = FMT_TIFF;
        end else if (ico) begin
            n_code = FMT_ICO;
        end else if ((r_count >= CNT_W'(8)) && r_ok[OK_WS1]) begin
            n_code = FMT_WSHOTS;
        end else if ((r_count >= CNT_W'(16)) && r_ok[OK_WS2]) begin
            n_code = FMT_WSHOTS;
        end else if ((r_count >= CNT_W'(12)) && r_ok[OK_PSD]) begin
            n_code = FMT_PSD;
        end else if ((r_count >= CNT_W'(16)) && r_ok[OK_RAS]) begin
            n_code = FMT_RAS;
        end else if ((r_count >= CNT_W'(52)) && r_ok[OK_J2K]) begin
            n_code = FMT_JPEG2000;
        end else if ((r_count >= CNT_W'(32)) && (r_ok[OK_JP2] || r_ok[OK_MJ2])) begin
            n_code = FMT_JPEG2000;
        end else if ((r_count >= CNT_W'(44)) && r_ok[OK_SFW]) begin
            n_code = FMT_SFW;
        end else if ((r_count >= CNT_W'(48)) && r_ok[OK_SVM]) begin
            n_code = FMT_SVM;
        end else if ((r_count >= CNT_W'(10)) && (r_ok[OK_SWF_F] || r_ok[OK_SWF_C])) begin
            n_code = FMT_SWF;
        end else begin
            n_code = FMT_UNKNOWN;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_format_code  = r_code;
    assign o_byte_count   = r_bc;

    // header store and icon read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && in_hdr) begin
            r_hdr[pos] <= i_data_byte;
        end
        r_rd_data <= r_hdr[rd_addr];
        r_rd_lane <= i_cmd.rd_lane;
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_mword[8*r_rd_lane +: 8] <= r_rd_data;
        end
        if (i_cmd.take && in_buf && (r_count == CNT_W'(6))) begin
            r_w6 <= i_data_byte;
        end
        if (i_cmd.emit) begin
            r_code <= n_code;
            r_bc   <= BCNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_off       <= '0;
            r_iw        <= '0;
            r_iwv       <= 1'b0;
            r_ok        <= '1;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                // file ends: start over for the next one
                r_count <= '0;
                r_off   <= '0;
                r_iw    <= '0;
                r_iwv   <= 1'b0;
                r_ok    <= '1;
            end else if (i_cmd.take && in_buf) begin
                r_count <= r_count + CNT_W'(1);
                if (in_hdr) begin
                    r_ok <= n_ok;
                end
                if ((r_count >= CNT_W'(18)) && (r_count <= CNT_W'(21))) begin
                    r_off[8*off_lane +: 8] <= i_data_byte;
                end
                if (cap) begin
                    r_iw[8*diff[1:0] +: 8] <= i_data_byte;
                    if (diff[1:0] == 2'd3) begin
                        r_iwv <= 1'b1;
                    end
                end
            end
        end
    end

    `ISF_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(BUFFER_BYTES), "byte count past buffer size")
    `ISF_ASSERT_NEXT(a_emit_restarts, i_cmd.emit, r_count == '0 && !r_iwv && r_out_valid, "file state not restarted after result")
    `ISF_ASSERT_IMPL(a_width_late, r_iwv, r_count >= CNT_W'(23), "icon width captured too early")

endmodule

`default_nettype wire

@@ rtl/core/image_format_sniffer.sv @@
// Image format sniffer, top level.
// Input channel i_in carries one file byte per word (data_byte) and last_byte,
// which marks the final byte of the file and closes it. Output channel o_out
// carries one word per file: format_code (0 unknown, 1..16 the detected type)
// and byte_count (bytes taken, saturating at the buffer size of 4096).
// Bytes past the buffer size are dropped; their last_byte mark still counts.
// Bytes of a file stream at one per cycle; ready drops only after its last byte.
// After the last byte, ready stays low while the controller steps through its
// states: four reads of the header memory fetch the icon width word, a merge
// step completes it, and an emit step loads the result register and sets
// o_out.valid once the output register is free.
// The result waits in its register while o_out.ready is low; bytes of the
// next file are taken meanwhile, and after its last byte the input stays held
// until the output register is free. Reset clears counters, flags and the
// output valid; the header memory is not cleared and no clearing pass runs.
// depends on isf_pkg, isf_ifs, isf_ctrl, isf_dpath
`default_nettype none

module image_format_sniffer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isf_in_if.sink    i_in,
    isf_out_if.source o_out
);
    import isf_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    isf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_byte),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    isf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_byte   (i_in.data_byte),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_format_code (o_out.format_code),
        .o_byte_count  (o_out.byte_count)
    );

endmodule

`default_nettype wire

@@ tb/tb_sniffer_checker.sv @@
// result checker of the image format sniffer testbench: follows both channels,
// predicts the format word of every file and compares it with the returned word
// depends on isf_pkg and isf_ifs
module tb_sniffer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    isf_in_if    i_in,
    isf_out_if   i_res,
    output int   o_mismatches,
    output int   o_pending
);
    import isf_pkg::*;

    localparam int unsigned WINDOW_BYTES = 4096;
    localparam int unsigned KEPT_BYTES   = 52;

    localparam logic [127:0] PNG_MAGIC  = 128'h89504E47_0D0A1A0A_0000000D_49484452;
    localparam logic [127:0] WS2_MAGIC  = 128'h00000200_0210C900_0200C806_4C000200;
    localparam logic [119:0] BOX_MAGIC  = 120'h0000000C_6A502020_0D0A870A_000000;
    localparam logic [351:0] SFW_MAGIC  = {128'h53465739_34410400_10000100_64000000,
                                           128'hCC000000_3B000000_DA070000_07010000,
                                           96'h44000000_D0070000_4B010000};
    localparam logic [383:0] SVM_MAGIC  = {128'h56434C4D_54460100_31000000_01000000,
                                           128'h01001B00_00000000_00000000_00000000,
                                           128'h01000000_01000000_01000000_01000000};

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BCNT_W-1:0] count;
    } t_format_word;

    logic [7:0]   kept_bytes [0:KEPT_BYTES-1];
    logic [31:0]  taken_bytes;
    logic [31:0]  icon_offset;
    logic [31:0]  icon_width;
    logic         icon_width_seen;
    t_format_word expected_formats [$];
    int           mismatches;

    // kept bytes from pos on equal a string whose first byte sits in the top lane
    function automatic logic bytes_are(input int pos, input int len, input logic [383:0] str);
        logic same;
        same = 1'b1;
        for (int k = 0; k < len; k++) begin
            if (kept_bytes[pos + k] != str[8*(len-1-k) +: 8]) same = 1'b0;
        end
        return same;
    endfunction

    function automatic logic icon_matches(input logic [31:0] n);
        logic [31:0] want;
        logic [31:0] word;
        logic [32:0] last_pos;
        int          s;
        if (n < 40 || kept_bytes[0] != 8'h00 || kept_bytes[1] != 8'h00) return 1'b0;
        if (icon_offset >= n - 32'd40) return 1'b0;
        want = (kept_bytes[6] == 8'h00) ? 32'd256 : {24'd0, kept_bytes[6]};
        last_pos = {1'b0, icon_offset} + 33'd7;
        if (last_pos < KEPT_BYTES) begin
            s    = int'(icon_offset) + 4;
            word = {kept_bytes[s+3], kept_bytes[s+2], kept_bytes[s+1], kept_bytes[s]};
        end else begin
            // width word lies past the kept header, use the captured one
            if (!icon_width_seen) return 1'b0;
            word = icon_width;
        end
        return word == want;
    endfunction

    // first matching signature wins, each one under its length guard
    function automatic logic [CODE_W-1:0] sniff_format(input logic [31:0] n);
        logic [7:0] b0, b1, b2, b3, b15, b16, b28;
        b0  = kept_bytes[0];
        b1  = kept_bytes[1];
        b2  = kept_bytes[2];
        b3  = kept_bytes[3];
        b15 = kept_bytes[15];
        b16 = kept_bytes[16];
        b28 = kept_bytes[28];
        if (n >= 34 && b0 == 8'h42 && b1 == 8'h4D && kept_bytes[6] == 8'h00
            && kept_bytes[7] == 8'h00 && kept_bytes[26] == 8'h01 && kept_bytes[27] == 8'h00
            && (b28 == 8'h00 || b28 == 8'h01 || b28 == 8'h04 || b28 == 8'h08
                || b28 == 8'h10 || b28 == 8'h18 || b28 == 8'h20)
            && kept_bytes[29] == 8'h00 && kept_bytes[30] <= 8'd5
            && bytes_are(31, 3, 384'(24'h000000)))
            return FMT_BMP;
        if (n >= 4 && bytes_are(0, 4, 384'(32'h47494638))) return FMT_GIF;
        if (n >= 16 && bytes_are(0, 16, 384'(PNG_MAGIC))) return FMT_PNG;
        if (n >= 17
            && ((b1 == 8'd1 && (b2 == 8'd1 || b2 == 8'd9))
                || (b1 == 8'd0 && (b2 == 8'd2 || b2 == 8'd3 || b2 == 8'd10 || b2 == 8'd11)))
            && (b16 == 8'd8 || b16 == 8'd16 || b16 == 8'd24 || b16 == 8'd32))
            return FMT_TGA;
        if (n >= 4 && b0 == 8'h0A && b1 <= 8'd5
            && (b3 == 8'd1 || b3 == 8'd2 || b3 == 8'd4 || b3 == 8'd8))
            return FMT_PCX;
        if (n >= 3 && bytes_are(0, 3, 384'(24'hFFD8FF))) return FMT_JPEG;
        if (n >= 44 && bytes_are(0, 4, 384'(32'h01000000))
            && bytes_are(40, 4, 384'(32'h20454D46)))
            return FMT_META;
        if (n >= 6 && (bytes_are(0, 6, 384'(48'hD7CDC69A0000))
                       || bytes_are(0, 6, 384'(48'h010009000003))))
            return FMT_META;
        if (n >= 4 && (bytes_are(0, 4, 384'(32'h49492A00))
                       || bytes_are(0, 4, 384'(32'h4D4D002A))))
            return FMT_TIFF;
        if (icon_matches(n)) return FMT_ICO;
        if (n >= 8 && bytes_are(0, 8, 384'(64'h57574242_31313131))) return FMT_WSHOTS;
        if (n >= 16 && bytes_are(0, 16, 384'(WS2_MAGIC))) return FMT_WSHOTS;
        if (n >= 12 && bytes_are(0, 4, 384'(32'h38425053))
            && bytes_are(6, 6, 384'(48'h000018000018)))
            return FMT_PSD;
        if (n >= 16 && bytes_are(0, 6, 384'(48'h59A66A950000)) && b15 == 8'h18)
            return FMT_RAS;
        if (n >= 52 && bytes_are(0, 4, 384'(32'hFF4FFF51))) return FMT_JPEG2000;
        if (n >= 32 && bytes_are(0, 15, 384'(BOX_MAGIC))
            && bytes_are(16, 8, 384'(64'h66747970_6A703220))
            && bytes_are(24, 4, 384'(32'h00000000)))
            return FMT_JPEG2000;
        if (n >= 32 && bytes_are(0, 15, 384'(BOX_MAGIC)) && b15 == 8'h18
            && bytes_are(16, 8, 384'(64'h66747970_6D6A7032))
            && bytes_are(24, 4, 384'(32'h00000000))
            && bytes_are(28, 4, 384'(32'h6D6A7032)))
            return FMT_JPEG2000;
        if (n >= 44 && bytes_are(0, 44, 384'(SFW_MAGIC))) return FMT_SFW;
        if (n >= 48 && bytes_are(0, 48, SVM_MAGIC)) return FMT_SVM;
        if (n >= 10 && ((bytes_are(0, 3, 384'(24'h465753)) && kept_bytes[9] == 8'h00)
                        || (bytes_are(0, 3, 384'(24'h435753)) && kept_bytes[8] == 8'h78
                            && kept_bytes[9] == 8'h9C)))
            return FMT_SWF;
        return FMT_UNKNOWN;
    endfunction

    always @(posedge i_clk) begin : follow
        t_format_word want;
        logic [31:0]  pos;
        logic [32:0]  lane_base;
        logic [32:0]  lane;
        if (!i_rst_n) begin
            for (int k = 0; k < KEPT_BYTES; k++) kept_bytes[k] = 8'h00;
            taken_bytes     = 0;
            icon_offset     = 0;
            icon_width      = 0;
            icon_width_seen = 1'b0;
            mismatches      = 0;
            expected_formats.delete();
        end else begin
            // result side first: a word leaving now cannot stem from a byte taken now
            if (i_res.valid && i_res.ready) begin
                if (expected_formats.size() == 0) begin
                    $display("%0t: result word with nothing expected: format %0d, count %0d",
                             $time, i_res.format_code, i_res.byte_count);
                    mismatches++;
                end else begin
                    want = expected_formats.pop_front();
                    if (i_res.format_code !== want.code) begin
                        $display("%0t: format_code mismatch: expected %0d, actual %0d",
                                 $time, want.code, i_res.format_code);
                        mismatches++;
                    end
                    if (i_res.byte_count !== want.count) begin
                        $display("%0t: byte_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, i_res.byte_count);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (taken_bytes < WINDOW_BYTES) begin
                    pos = taken_bytes;
                    if (pos < KEPT_BYTES) kept_bytes[pos] = i_in.data_byte;
                    if (pos >= 18 && pos <= 21)
                        icon_offset |= {24'd0, i_in.data_byte} << (8 * (pos - 18));
                    if (pos >= 22) begin
                        lane_base = {1'b0, icon_offset} + 33'd4;
                        if ({1'b0, pos} >= lane_base && {1'b0, pos} - lane_base < 33'd4) begin
                            lane = {1'b0, pos} - lane_base;
                            icon_width |= {24'd0, i_in.data_byte} << (8 * lane);
                            if (lane == 33'd3) icon_width_seen = 1'b1;
                        end
                    end
                    taken_bytes = pos + 1;
                end
                if (i_in.last_byte) begin
                    want.code  = sniff_format(taken_bytes);
                    want.count = taken_bytes[BCNT_W-1:0];
                    expected_formats.push_back(want);
                    taken_bytes     = 0;
                    icon_offset     = 0;
                    icon_width      = 0;
                    icon_width_seen = 1'b0;
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_formats.size();
    end

endmodule

@@ tb/tb_image_format_sniffer.sv @@
// top of the image format sniffer testbench: clock, reset, file stimulus with
// random gaps on both channels, and the verdict from the result checker
// depends on isf_pkg, isf_ifs, image_format_sniffer and tb_sniffer_checker
module tb_image_format_sniffer;
    import isf_pkg::*;

    localparam int RANDOM_BYTES = 1050;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int BUF_BYTES    = 512;

    localparam logic [55:0] BMP_DEPTHS = 56'h00_01_04_08_10_18_20;
    localparam logic [95:0] TGA_PAIRS  = 96'h0101_0002_0003_0109_000A_000B;
    localparam logic [31:0] TGA_DEPTHS = 32'h08_10_18_20;
    localparam logic [31:0] PCX_PLANES = 32'h01_02_04_08;

    typedef enum int {
        K_NOISE, K_BMP, K_GIF, K_PNG, K_TGA, K_PCX, K_JPEG, K_EMF, K_WMF_A, K_WMF_B,
        K_TIFF_I, K_TIFF_M, K_ICO, K_WS1, K_WS2, K_PSD, K_RAS, K_J2K, K_JP2, K_MJ2,
        K_SFW, K_SVM, K_SWF_F, K_SWF_C, K_COUNT
    } t_file_kind;

    logic       i_clk;
    logic       i_rst_n;
    int         mismatches;
    int         pending;
    int         stall_cycles = 0;
    logic       calm = 1'b0;
    logic       hold_req = 1'b0;
    logic       hold_taken = 1'b0;
    logic [7:0] file_buf [0:BUF_BYTES-1];

    isf_in_if  in_ch ();
    isf_out_if res_ch ();

    image_format_sniffer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    tb_sniffer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(99, 0) < 11) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_string(input logic [383:0] str, input int len);
        for (int k = 0; k < len; k++) send_byte(str[8*(len-1-k) +: 8], k == len - 1);
    endtask

    // bytes past the built header are plain random
    task automatic send_file(input int len);
        for (int i = 0; i < len; i++)
            send_byte((i < BUF_BYTES) ? file_buf[i] : 8'($urandom_range(255, 0)),
                      i == len - 1);
    endtask

    task automatic place(input int pos, input int len, input logic [383:0] str);
        for (int k = 0; k < len; k++) file_buf[pos + k] = str[8*(len-1-k) +: 8];
    endtask

    // random file header, mostly one well-formed signature with random content
    task automatic build_file(output int len);
        t_file_kind  kind;
        int          guard;
        int          pick;
        int          offset;
        int          width;
        logic [15:0] pair;
        for (int i = 0; i < BUF_BYTES; i++) file_buf[i] = 8'($urandom_range(255, 0));
        kind  = t_file_kind'($urandom_range(int'(K_COUNT) - 1, 0));
        guard = 1;
        case (kind)
            K_BMP: begin
                place(0, 2, 384'(16'h424D));
                place(6, 2, 384'(16'h0000));
                place(26, 2, 384'(16'h0100));
                file_buf[28] = BMP_DEPTHS[8*$urandom_range(6, 0) +: 8];
                file_buf[29] = 8'h00;
                file_buf[30] = 8'($urandom_range(5, 0));
                place(31, 3, 384'(24'h000000));
                guard = 34;
            end
            K_GIF: begin
                place(0, 4, 384'(32'h47494638));
                guard = 4;
            end
            K_PNG: begin
                place(0, 16, SIG_PNG);
                guard = 16;
            end
            K_TGA: begin
                pair         = TGA_PAIRS[16*$urandom_range(5, 0) +: 16];
                file_buf[1]  = pair[15:8];
                file_buf[2]  = pair[7:0];
                file_buf[16] = TGA_DEPTHS[8*$urandom_range(3, 0) +: 8];
                guard = 17;
            end
            K_PCX: begin
                file_buf[0] = 8'h0A;
                file_buf[1] = 8'($urandom_range(5, 0));
                file_buf[3] = PCX_PLANES[8*$urandom_range(3, 0) +: 8];
                guard = 4;
            end
            K_JPEG: begin
                place(0, 3, 384'(24'hFFD8FF));
                guard = 3;
            end
            K_EMF: begin
                place(0, 4, 384'(32'h01000000));
                place(40, 4, 384'(32'h20454D46));
                guard = 44;
            end
            K_WMF_A: begin
                place(0, 6, 384'(48'hD7CDC69A0000));
                guard = 6;
            end
            K_WMF_B: begin
                place(0, 6, 384'(48'h010009000003));
                guard = 6;
            end
            K_TIFF_I: begin
                place(0, 4, 384'(32'h49492A00));
                guard = 4;
            end
            K_TIFF_M: begin
                place(0, 4, 384'(32'h4D4D002A));
                guard = 4;
            end
            K_ICO: begin
                // width word inside the kept header, or past it
                pick = $urandom_range(99, 0);
                if (pick < 30) offset = $urandom_range(10, 3);
                else if (pick < 65) offset = $urandom_range(44, 18);
                else offset = $urandom_range(150, 48);
                width = $urandom_range(255, 0);
                if ($urandom_range(3, 0) == 0) width = 0;
                place(0, 2, 384'(16'h0000));
                file_buf[6] = width[7:0];
                place(18, 4, 384'({offset[7:0], offset[15:8], offset[23:16], offset[31:24]}));
                if (width == 0) width = 256;
                place(offset + 4, 4,
                      384'({width[7:0], width[15:8], width[23:16], width[31:24]}));
                guard = offset + 41;
            end
            K_WS1: begin
                place(0, 8, 384'(64'h57574242_31313131));
                guard = 8;
            end
            K_WS2: begin
                place(0, 16, SIG_WB2);
                guard = 16;
            end
            K_PSD: begin
                place(0, 4, 384'(32'h38425053));
                place(6, 6, 384'(48'h000018000018));
                guard = 12;
            end
            K_RAS: begin
                place(0, 6, 384'(48'h59A66A950000));
                file_buf[15] = 8'h18;
                guard = 16;
            end
            K_J2K: begin
                place(0, 4, 384'(32'hFF4FFF51));
                guard = 52;
            end
            K_JP2: begin
                place(0, 15, SIG_BOX);
                place(16, 8, 384'(64'h66747970_6A703220));
                place(24, 4, 384'(32'h00000000));
                guard = 32;
            end
            K_MJ2: begin
                place(0, 15, SIG_BOX);
                file_buf[15] = 8'h18;
                place(16, 8, 384'(64'h66747970_6D6A7032));
                place(24, 4, 384'(32'h00000000));
                place(28, 4, 384'(32'h6D6A7032));
                guard = 32;
            end
            K_SFW: begin
                place(0, 44, SIG_SFW);
                guard = 44;
            end
            K_SVM: begin
                place(0, 48, SIG_SVM);
                guard = 48;
            end
            K_SWF_F: begin
                place(0, 3, 384'(24'h465753));
                file_buf[9] = 8'h00;
                guard = 10;
            end
            K_SWF_C: begin
                place(0, 3, 384'(24'h435753));
                place(8, 2, 384'(16'h789C));
                guard = 10;
            end
            default: begin
                // leading zeros reach the icon, webshots and jp2 prefixes
                if ($urandom_range(9, 0) < 3) place(0, 2, 384'(16'h0000));
                guard = $urandom_range(60, 1);
            end
        endcase
        if ($urandom_range(9, 0) == 0) file_buf[$urandom_range(51, 0)] = 8'($urandom_range(255, 0));
        pick = $urandom_range(99, 0);
        if (pick < 12) len = $urandom_range(guard, 1);
        else if (pick < 18) len = guard + $urandom_range(120, 25);
        else len = guard + $urandom_range(20, 0);
    endtask

    // receiver: random stalls, one long hold-off, none in the calm stretch
    initial begin
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req && !hold_taken) begin
                res_ch.ready <= 1'b0;
                hold_taken = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_ch.ready <= calm || ($urandom_range(99, 0) >= 11);
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int file_len;
        int sent;
        int files;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shortest files and the short signatures at their length limits
        send_string(384'(8'h00), 1);
        send_string(384'(8'hFF), 1);
        send_string(384'(32'h47494638), 4);
        send_string(384'(24'hFFD8FF), 3);
        send_string(384'(32'h0A050008), 4);
        send_string(384'(32'h49492A00), 4);
        send_string(384'(32'h4D4D002A), 4);
        send_string(384'(24'h4D4D00), 3);

        hold_req = 1'b1;
        sent     = 0;
        files    = 0;
        while (sent < RANDOM_BYTES) begin
            if (files == 8) begin
                // let every pending result drain before the next file
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            calm = (files >= 20 && files < 34);
            build_file(file_len);
            send_file(file_len);
            sent  += file_len;
            files += 1;
        end
        calm = 1'b0;

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // nothing moving on either channel for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
